@@ src/ats_pkg.sv @@
// ----------------------------------------------------------------------------
// ats_pkg
// Shared types and constants for the alias table sampler: widths, request
// and status codes, and the request and response beat layouts.
// ----------------------------------------------------------------------------
package ats_pkg;

	localparam int MAX_ENTRIES = 256;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = IDX_W + 1;
	localparam int CFG_W       = 9;
	localparam int WGT_W       = 32;
	localparam int VAL_W       = 40;
	localparam int PROD_W      = VAL_W + 1;

	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_BUILD  = 2'd1;
	localparam logic [1:0] REQ_SAMPLE = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_BUILT = 2'd1;
	localparam logic [1:0] ST_RANGE     = 2'd2;

	typedef struct packed {
		logic [1:0]              req_type;
		logic [IDX_W-1:0]        entry_index;
		logic signed [WGT_W-1:0] weight;
		logic [VAL_W-1:0]        weight_total;
		logic [VAL_W-1:0]        threshold_u;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0] sample_index;
		logic             took_alias;
		logic [1:0]       status;
	} rsp_t;

endpackage

@@ src/ats_ram.sv @@
// ----------------------------------------------------------------------------
// ats_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ats_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	assign rdata = rd_q;

endmodule

@@ src/alias_table_sampler.sv @@
// ----------------------------------------------------------------------------
// alias_table_sampler
// Alias-method sampler: weight store, worklist table build, two-read sample.
// ----------------------------------------------------------------------------
// Every request returns exactly one response beat. A sample reads the
// threshold and the alias, then makes one 40-bit compare; a load multiplies
// the magnitude by the entries in use, then writes the weight store. A build
// of n entries first copies and sorts the weights onto the worklists, then
// handles each paired entry and then each leftover entry in turn;
// its pace is set by the single read port of the working weight RAM and the
// one shared 40-bit adder and compare unit. When the response register is
// still held by an earlier beat, the block waits in a done state until it
// frees. The request side is stalled while a request is in work, but a new
// request is taken while a finished response waits. All stores power up
// undefined; no clearing pass.
// ----------------------------------------------------------------------------
module alias_table_sampler (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [ats_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  ats_pkg::req_t          req_data,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output ats_pkg::rsp_t          rsp_data
);

	import ats_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_LDWR, S_CRD, S_CWR, S_PPOP, S_PLO, S_PHI, S_PUPD,
		S_LPOP, S_LWR, S_SCMP, S_DONE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] n_q, sc_q, lc_q, i_q;
	logic             built_q, from_large_q, rsp_valid_q;
	logic [VAL_W-1:0] total_q, u_q, mul_q, wlo_q, dlo_q;
	logic [IDX_W-1:0] idx_q, lo_q, hi_q;
	rsp_t             res_q, rsp_q, fin_res, rsp_next;
	logic             fin, accept, slot_free, in_range;
	logic             rsp_load, built_clr, built_set;
	logic [WGT_W-1:0] mag;
	logic [PROD_W-1:0] prod;
	logic [VAL_W-1:0] upd_sum, alu_b, cmp_a, cmp_b;
	logic             cmp_lt, smp_hit;
	logic [IDX_W-1:0] lw_k, small_top, large_top;

	logic             sw_we, wk_we, th_we, al_we, sl_we, ll_we;
	logic [IDX_W-1:0] sw_waddr, wk_waddr, th_waddr, al_waddr, sl_waddr, ll_waddr;
	logic [IDX_W-1:0] wk_raddr, al_wdata, sl_wdata, ll_wdata;
	logic [VAL_W-1:0] sw_wdata, wk_wdata, th_wdata;
	logic [VAL_W-1:0] sw_rd, wk_rd, th_rd;
	logic [IDX_W-1:0] al_rd, sl_rd, ll_rd;

	function automatic logic [CNT_W-1:0] clamp_n(input logic [CFG_W-1:0] v);
		if (v == '0) begin
			return CNT_W'(1);
		end
		if (int'(v) > MAX_ENTRIES) begin
			return CNT_W'(MAX_ENTRIES);
		end
		return CNT_W'(v);
	endfunction

	function automatic rsp_t status_rsp(input logic [1:0] st);
		rsp_t r;
		r        = '0;
		r.status = st;
		return r;
	endfunction

	ats_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ENTRIES)) u_scaled (
		.clk(clk), .we(sw_we), .waddr(sw_waddr), .wdata(sw_wdata),
		.raddr(i_q[IDX_W-1:0]), .rdata(sw_rd)
	);
	ats_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ENTRIES)) u_work (
		.clk(clk), .we(wk_we), .waddr(wk_waddr), .wdata(wk_wdata),
		.raddr(wk_raddr), .rdata(wk_rd)
	);
	ats_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ENTRIES)) u_thresh (
		.clk(clk), .we(th_we), .waddr(th_waddr), .wdata(th_wdata),
		.raddr(req_data.entry_index), .rdata(th_rd)
	);
	ats_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_alias (
		.clk(clk), .we(al_we), .waddr(al_waddr), .wdata(al_wdata),
		.raddr(req_data.entry_index), .rdata(al_rd)
	);
	ats_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_small (
		.clk(clk), .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
		.raddr(small_top), .rdata(sl_rd)
	);
	ats_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_large (
		.clk(clk), .we(ll_we), .waddr(ll_waddr), .wdata(ll_wdata),
		.raddr(large_top), .rdata(ll_rd)
	);

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	assign rsp_load  = slot_free && (fin || state_q == S_DONE);
	assign rsp_next  = fin ? fin_res : res_q;
	assign built_clr = cfg_we || (accept && req_data.req_type == REQ_LOAD);
	assign built_set = fin && (state_q == S_LPOP);

	assign in_range  = CNT_W'(req_data.entry_index) < n_q;
	assign mag       = req_data.weight[WGT_W-1] ? $unsigned(~req_data.weight + WGT_W'(1))
	                                            : $unsigned(req_data.weight);
	assign prod      = PROD_W'(mag) * PROD_W'(n_q);

	// worklist tops: entry below the current count
	assign small_top = IDX_W'(sc_q - CNT_W'(1));
	assign large_top = IDX_W'(lc_q - CNT_W'(1));

	// shared 40-bit adder: work[lo] - total in S_PHI, work[hi] plus that in S_PUPD
	assign alu_b     = (state_q == S_PHI) ? ~total_q : dlo_q;
	assign upd_sum   = wk_rd + alu_b + VAL_W'(state_q == S_PHI);
	// shared 40-bit compare
	assign cmp_a     = (state_q == S_SCMP) ? th_rd
	                 : ((state_q == S_PUPD) ? upd_sum : sw_rd);
	assign cmp_b     = (state_q == S_SCMP) ? u_q : total_q;
	assign cmp_lt    = cmp_a < cmp_b;
	assign smp_hit   = !cmp_lt;
	assign lw_k      = from_large_q ? ll_rd : sl_rd;

	always_comb begin
		sw_we    = 1'b0;
		sw_waddr = idx_q;
		sw_wdata = mul_q;
		wk_we    = 1'b0;
		wk_waddr = hi_q;
		wk_wdata = upd_sum;
		wk_raddr = hi_q;
		th_we    = 1'b0;
		th_waddr = lo_q;
		th_wdata = wlo_q;
		al_we    = 1'b0;
		al_waddr = lo_q;
		al_wdata = hi_q;
		sl_we    = 1'b0;
		sl_waddr = sc_q[IDX_W-1:0];
		sl_wdata = hi_q;
		ll_we    = 1'b0;
		ll_waddr = lc_q[IDX_W-1:0];
		ll_wdata = hi_q;
		fin      = 1'b0;
		fin_res  = '0;
		case (state_q)
			S_LDWR: begin
				sw_we = 1'b1;
				fin   = 1'b1;
			end
			S_CWR: begin
				wk_we    = 1'b1;
				wk_waddr = i_q[IDX_W-1:0];
				wk_wdata = sw_rd;
				sl_wdata = i_q[IDX_W-1:0];
				ll_wdata = i_q[IDX_W-1:0];
				sl_we    = cmp_lt;
				ll_we    = !cmp_lt;
			end
			S_PLO: begin
				wk_raddr = sl_rd;
			end
			S_PUPD: begin
				th_we = 1'b1;
				al_we = 1'b1;
				wk_we = 1'b1;
				sl_we = cmp_lt;
				ll_we = !cmp_lt;
			end
			S_LPOP: begin
				fin = (lc_q == '0) && (sc_q == '0);
			end
			S_LWR: begin
				th_we    = 1'b1;
				th_waddr = lw_k;
				th_wdata = total_q;
				al_we    = 1'b1;
				al_waddr = lw_k;
				al_wdata = lw_k;
			end
			S_SCMP: begin
				fin                  = 1'b1;
				fin_res.sample_index = smp_hit ? idx_q : al_rd;
				fin_res.took_alias   = !smp_hit;
				fin_res.status       = ST_OK;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			n_q          <= CNT_W'(MAX_ENTRIES);
			built_q      <= 1'b0;
			sc_q         <= '0;
			lc_q         <= '0;
			i_q          <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				n_q <= clamp_n(cfg_wdata);
			end
			if (built_clr) begin
				built_q <= 1'b0;
			end else if (built_set) begin
				built_q <= 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= rsp_next;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q   <= req_data.entry_index;
						total_q <= req_data.weight_total;
						u_q     <= req_data.threshold_u;
						mul_q   <= prod[VAL_W-1:0];
						case (req_data.req_type)
							REQ_LOAD: begin
								if (in_range) begin
									state_q <= S_LDWR;
								end else begin
									res_q   <= status_rsp(ST_RANGE);
									state_q <= S_DONE;
								end
							end
							REQ_BUILD: begin
								i_q     <= '0;
								sc_q    <= '0;
								lc_q    <= '0;
								state_q <= S_CRD;
							end
							REQ_SAMPLE: begin
								if (!built_q) begin
									res_q   <= status_rsp(ST_NOT_BUILT);
									state_q <= S_DONE;
								end else if (!in_range) begin
									res_q   <= status_rsp(ST_RANGE);
									state_q <= S_DONE;
								end else begin
									state_q <= S_SCMP;
								end
							end
							default: begin
								res_q   <= status_rsp(ST_OK);
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_CRD: begin
					state_q <= S_CWR;
				end
				S_CWR: begin
					i_q <= i_q + CNT_W'(1);
					if (cmp_lt) begin
						sc_q <= sc_q + CNT_W'(1);
					end else begin
						lc_q <= lc_q + CNT_W'(1);
					end
					state_q <= (i_q + CNT_W'(1) == n_q) ? S_PPOP : S_CRD;
				end
				S_PPOP: begin
					if (sc_q != '0 && lc_q != '0) begin
						sc_q    <= sc_q - CNT_W'(1);
						lc_q    <= lc_q - CNT_W'(1);
						state_q <= S_PLO;
					end else begin
						state_q <= S_LPOP;
					end
				end
				S_PLO: begin
					lo_q    <= sl_rd;
					hi_q    <= ll_rd;
					state_q <= S_PHI;
				end
				S_PHI: begin
					// small weight is below total, so this wraps; the sum comes back
					wlo_q   <= wk_rd;
					dlo_q   <= upd_sum;
					state_q <= S_PUPD;
				end
				S_PUPD: begin
					if (cmp_lt) begin
						sc_q <= sc_q + CNT_W'(1);
					end else begin
						lc_q <= lc_q + CNT_W'(1);
					end
					state_q <= S_PPOP;
				end
				S_LPOP: begin
					if (lc_q != '0) begin
						from_large_q <= 1'b1;
						lc_q         <= lc_q - CNT_W'(1);
						state_q      <= S_LWR;
					end else if (sc_q != '0) begin
						from_large_q <= 1'b0;
						sc_q         <= sc_q - CNT_W'(1);
						state_q      <= S_LWR;
					end
				end
				S_LWR: begin
					state_q <= S_LPOP;
				end
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
				end
			endcase
			if (fin) begin
				if (slot_free) begin
					state_q <= S_IDLE;
				end else begin
					res_q   <= fin_res;
					state_q <= S_DONE;
				end
			end
		end
	end

	// worklists never hold more than the entries in use
	a_list_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((CNT_W+1)'(sc_q) + (CNT_W+1)'(lc_q)) <= (CNT_W+1)'(n_q))
		else $error("worklist counts exceed entries in use");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> (sc_q == '0 && lc_q == '0))
		else $error("worklists not empty while idle");

	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req_data.req_type == REQ_LOAD |=> !built_q)
		else $error("tables still marked built after a load");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status != ST_OK
		|-> (rsp_data.sample_index == '0 && !rsp_data.took_alias))
		else $error("error response carries a sample");

endmodule
